// ===== rtl/core/triangle_plane_intersect_top_defines.svh =====
// Assertion macros shared by the triangle/plane intersection RTL.
`ifndef TRIANGLE_PLANE_INTERSECT_TOP_DEFINES_SVH
`define TRIANGLE_PLANE_INTERSECT_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clk outside reset
`define TPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tpi_pkg.sv =====
// Shared constants for the triangle/plane intersection pipeline.
package tpi_pkg;

  // Port field width and default coordinate width
  localparam int FIELD_W         = 32;
  localparam int COORD_WIDTH_DEF = 32;

  // Lanes: first x, first y, second x, second y
  localparam int LANES = 4;

  // Edge codes
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

endpackage

// ===== rtl/core/tpi_sel.sv =====
// Front end: crossing test, edge selection and operand magnitudes (3 stages).
module tpi_sel #(
  parameter int W = tpi_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [tpi_pkg::FIELD_W-1:0]            a_x,
  input  logic [tpi_pkg::FIELD_W-1:0]            a_y,
  input  logic [tpi_pkg::FIELD_W-1:0]            a_z,
  input  logic [tpi_pkg::FIELD_W-1:0]            b_x,
  input  logic [tpi_pkg::FIELD_W-1:0]            b_y,
  input  logic [tpi_pkg::FIELD_W-1:0]            b_z,
  input  logic [tpi_pkg::FIELD_W-1:0]            c_x,
  input  logic [tpi_pkg::FIELD_W-1:0]            c_y,
  input  logic [tpi_pkg::FIELD_W-1:0]            c_z,
  input  logic [tpi_pkg::FIELD_W-1:0]            plane_z,
  output logic                                   valid,
  output logic                                   hit,
  output logic [tpi_pkg::LANES-1:0][W:0]         num_mag,
  output logic [tpi_pkg::LANES-1:0][W:0]         d_mag,
  output logic [tpi_pkg::LANES-1:0][W:0]         den_mag,
  output logic [tpi_pkg::LANES-1:0]              neg,
  output logic [tpi_pkg::LANES-1:0]              found,
  output logic [tpi_pkg::LANES-1:0][W-1:0]       base
);
  import tpi_pkg::*;

  // Low W bits of a field, sign bit at W-1
  function automatic logic [W-1:0] sx(input logic [FIELD_W-1:0] v);
    logic [2*FIELD_W-1:0] t;
    t = (2*FIELD_W)'(v);
    return t[W-1:0];
  endfunction

  // Next vertex of an edge
  function automatic logic [1:0] nxt(input logic [1:0] e);
    logic [1:0] r;
    case (e)
      EDGE_AB: r = EDGE_BC;
      EDGE_BC: r = EDGE_CA;
      default: r = EDGE_AB;
    endcase
    return r;
  endfunction

  // Stage A: truncation to W bits and crossing flags
  logic [2:0][W-1:0] in_x, in_y, in_z;
  logic [W-1:0]      in_pz;
  logic [2:0]        in_cross;

  logic [2:0][W-1:0] sa_x, sa_y, sa_z;
  logic [W-1:0]      sa_pz;
  logic [2:0]        sa_cross;
  logic              sa_valid;

  always_comb begin
    int j;
    in_x[0] = sx(a_x); in_y[0] = sx(a_y); in_z[0] = sx(a_z);
    in_x[1] = sx(b_x); in_y[1] = sx(b_y); in_z[1] = sx(b_z);
    in_x[2] = sx(c_x); in_y[2] = sx(c_y); in_z[2] = sx(c_z);
    in_pz   = sx(plane_z);
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      in_cross[i] = ($signed(in_z[i]) <= $signed(in_pz) && $signed(in_z[j]) > $signed(in_pz)) ||
                    ($signed(in_z[j]) <= $signed(in_pz) && $signed(in_z[i]) > $signed(in_pz));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= in_valid;
    end
    if (en) begin
      sa_x     <= in_x;
      sa_y     <= in_y;
      sa_z     <= in_z;
      sa_pz    <= in_pz;
      sa_cross <= in_cross;
    end
  end

  // Stage B: pick the first two crossing edges, take differences
  logic [1:0]        f_idx, s_idx;
  logic [1:0]        pt_found;
  logic              pt_hit;
  logic [1:0][W:0]   nb_num, nb_den, nb_dx, nb_dy;

  logic [1:0][W:0]   sb_num, sb_den, sb_dx, sb_dy;
  logic [1:0][W-1:0] sb_bx, sb_by;
  logic [1:0]        sb_found;
  logic              sb_hit;
  logic              sb_valid;
  logic [1:0][1:0]   vi, vj;

  always_comb begin
    f_idx = sa_cross[0] ? EDGE_AB : (sa_cross[1] ? EDGE_BC : EDGE_CA);
    s_idx = (sa_cross[0] && sa_cross[1]) ? EDGE_BC : EDGE_CA;
    pt_found[0] = |sa_cross;
    pt_found[1] = (sa_cross[0] & sa_cross[1]) | (sa_cross[0] & sa_cross[2]) |
                  (sa_cross[1] & sa_cross[2]);
    pt_hit      = pt_found[1] & ~(&sa_cross);
    vi[0] = f_idx;
    vi[1] = s_idx;
    for (int p = 0; p < 2; p++) begin
      vj[p]     = nxt(vi[p]);
      nb_num[p] = {sa_pz[W-1], sa_pz} - {sa_z[vi[p]][W-1], sa_z[vi[p]]};
      nb_den[p] = {sa_z[vj[p]][W-1], sa_z[vj[p]]} - {sa_z[vi[p]][W-1], sa_z[vi[p]]};
      nb_dx[p]  = {sa_x[vj[p]][W-1], sa_x[vj[p]]} - {sa_x[vi[p]][W-1], sa_x[vi[p]]};
      nb_dy[p]  = {sa_y[vj[p]][W-1], sa_y[vj[p]]} - {sa_y[vi[p]][W-1], sa_y[vi[p]]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en) begin
      sb_valid <= sa_valid;
    end
    if (en) begin
      sb_num   <= nb_num;
      sb_den   <= nb_den;
      sb_dx    <= nb_dx;
      sb_dy    <= nb_dy;
      sb_bx[0] <= sa_x[vi[0]];
      sb_bx[1] <= sa_x[vi[1]];
      sb_by[0] <= sa_y[vi[0]];
      sb_by[1] <= sa_y[vi[1]];
      sb_found <= pt_found;
      sb_hit   <= pt_hit;
    end
  end

  // Stage C: magnitudes and quotient sign per lane
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= sb_valid;
    end
    if (en) begin
      hit <= sb_hit;
      for (int l = 0; l < LANES; l++) begin
        num_mag[l] <= sb_num[l/2][W] ? (W+1)'(-sb_num[l/2]) : sb_num[l/2];
        den_mag[l] <= sb_den[l/2][W] ? (W+1)'(-sb_den[l/2]) : sb_den[l/2];
        if (l % 2 == 1) begin
          d_mag[l] <= sb_dy[l/2][W] ? (W+1)'(-sb_dy[l/2]) : sb_dy[l/2];
          neg[l]   <= sb_num[l/2][W] ^ sb_dy[l/2][W] ^ sb_den[l/2][W];
          base[l]  <= sb_by[l/2];
        end else begin
          d_mag[l] <= sb_dx[l/2][W] ? (W+1)'(-sb_dx[l/2]) : sb_dx[l/2];
          neg[l]   <= sb_num[l/2][W] ^ sb_dx[l/2][W] ^ sb_den[l/2][W];
          base[l]  <= sb_bx[l/2];
        end
        found[l] <= sb_found[l/2];
      end
    end
  end

endmodule

// ===== rtl/core/tpi_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
module tpi_mul #(
  parameter int W  = tpi_pkg::COORD_WIDTH_DEF,
  parameter int SW = tpi_pkg::COORD_WIDTH_DEF + 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [W:0]      a,
  input  logic [W:0]      b,
  input  logic [W:0]      den,
  input  logic [SW-1:0]   side,
  output logic            valid,
  output logic [2*W+1:0]  prod,
  output logic [W:0]      den_o,
  output logic [SW-1:0]   side_o
);
  localparam int H  = (W + 2) / 2;
  localparam int PW = 4 * H;

  logic [H-1:0]   al, ah, bl, bh;
  logic [2*H-1:0] p00, p01, p10, p11;
  logic [W:0]     den1;
  logic [SW-1:0]  side1;
  logic           v1;
  logic [PW-1:0]  sum;

  // Operand halves
  always_comb begin
    al = a[H-1:0];
    ah = H'(a[W:H]);
    bl = b[H-1:0];
    bh = H'(b[W:H]);
  end

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      p00   <= al * bl;
      p01   <= al * bh;
      p10   <= ah * bl;
      p11   <= ah * bh;
      den1  <= den;
      side1 <= side;
    end
  end

  // Stage 2: combine
  assign sum = PW'(p00) + ((PW'(p01) + PW'(p10)) << H) + (PW'(p11) << (2 * H));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v1;
    end
    if (en) begin
      prod   <= sum[2*W+1:0];
      den_o  <= den1;
      side_o <= side1;
    end
  end

endmodule

// ===== rtl/core/tpi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage (W+2 stages).
module tpi_div #(
  parameter int W  = tpi_pkg::COORD_WIDTH_DEF,
  parameter int SW = tpi_pkg::COORD_WIDTH_DEF + 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*W+1:0]  prod,
  input  logic [W:0]      den,
  input  logic [SW-1:0]   side,
  output logic            valid,
  output logic [W:0]      quot,
  output logic [SW-1:0]   side_o
);
  localparam int N = W + 1;

  // Quotient fits W+1 bits, so the top W+1 dividend bits start below den
  logic [W:0]    rem_r  [N+1];
  logic [W:0]    low_r  [N+1];
  logic [W:0]    q_r    [N+1];
  logic [W:0]    den_r  [N+1];
  logic [SW-1:0] side_r [N+1];
  logic [N:0]    v_r;

  // Stage 0: load
  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0]  <= prod[2*W+1:W+1];
      low_r[0]  <= prod[W:0];
      q_r[0]    <= '0;
      den_r[0]  <= den;
      side_r[0] <= side;
    end
  end

  // One compare and subtract per stage
  for (genvar s = 1; s <= N; s++) begin : g_step
    logic [W+1:0] r2;
    logic [W+1:0] diff;
    logic         ge;

    always_comb begin
      r2   = {rem_r[s-1], low_r[s-1][W]};
      diff = r2 - {1'b0, den_r[s-1]};
      ge   = r2 >= {1'b0, den_r[s-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_r[s-1];
      end
      if (en) begin
        rem_r[s]  <= ge ? diff[W:0] : r2[W:0];
        low_r[s]  <= {low_r[s-1][W-1:0], 1'b0};
        q_r[s]    <= {q_r[s-1][W-1:0], ge};
        den_r[s]  <= den_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign valid  = v_r[N];
  assign quot   = q_r[N];
  assign side_o = side_r[N];

endmodule

// ===== rtl/core/triangle_plane_intersect_top.sv =====
// Top level of the triangle/horizontal plane intersection pipeline.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+---------------------------------------------
//  in      | in_valid / in_ready | a_*, b_*, c_* vertices, plane_z (Q16.16)
//  out     | out_valid/out_ready | first_x/y, second_x/y (Q16.16), hit
//
//  One triangle accepted per cycle while no result is held at the output; the
//  path runs through 3 front-end stages, 2 multiplier stages, the bit-per-stage
//  dividers (COORD_WIDTH+2 stages) and the output register.
//  Reset clears only the valid bits; payload registers are not reset.
//  A result held at the output without out_ready freezes every stage together.
module triangle_plane_intersect_top #(
  parameter int COORD_WIDTH = tpi_pkg::COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tpi_pkg::FIELD_W-1:0]  a_x,
  input  logic [tpi_pkg::FIELD_W-1:0]  a_y,
  input  logic [tpi_pkg::FIELD_W-1:0]  a_z,
  input  logic [tpi_pkg::FIELD_W-1:0]  b_x,
  input  logic [tpi_pkg::FIELD_W-1:0]  b_y,
  input  logic [tpi_pkg::FIELD_W-1:0]  b_z,
  input  logic [tpi_pkg::FIELD_W-1:0]  c_x,
  input  logic [tpi_pkg::FIELD_W-1:0]  c_y,
  input  logic [tpi_pkg::FIELD_W-1:0]  c_z,
  input  logic [tpi_pkg::FIELD_W-1:0]  plane_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tpi_pkg::FIELD_W-1:0]  first_x,
  output logic [tpi_pkg::FIELD_W-1:0]  first_y,
  output logic [tpi_pkg::FIELD_W-1:0]  second_x,
  output logic [tpi_pkg::FIELD_W-1:0]  second_y,
  output logic                         hit
);
  import tpi_pkg::*;
  `include "triangle_plane_intersect_top_defines.svh"

  localparam int W  = COORD_WIDTH;
  localparam int SW = W + 3;

  logic en;

  // Front end outputs
  logic                        sel_valid;
  logic                        sel_hit;
  logic [LANES-1:0][W:0]       num_mag, d_mag, den_mag;
  logic [LANES-1:0]            sel_neg, sel_found;
  logic [LANES-1:0][W-1:0]     sel_base;

  // Lane signals
  logic [LANES-1:0]            mul_valid, div_valid;
  logic [LANES-1:0][2*W+1:0]   prod;
  logic [LANES-1:0][W:0]       mul_den, quot;
  logic [LANES-1:0][SW-1:0]    lane_side, mul_side, div_side;
  logic [LANES-1:0][FIELD_W-1:0] res;
  logic [LANES-1:0]            lane_hit;

  // Whole pipeline advances unless a result is waiting
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  tpi_sel #(.W(W)) u_sel (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .plane_z(plane_z),
    .valid(sel_valid), .hit(sel_hit),
    .num_mag(num_mag), .d_mag(d_mag), .den_mag(den_mag),
    .neg(sel_neg), .found(sel_found), .base(sel_base)
  );

  // Four interpolation lanes: multiply then divide
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [W:0] base_e;
    logic signed [W:0] sum_e;

    assign lane_side[l] = {sel_hit, sel_found[l], sel_neg[l], sel_base[l]};

    tpi_mul #(.W(W), .SW(SW)) u_mul (
      .clk(clk), .rst(rst), .en(en), .in_valid(sel_valid),
      .a(num_mag[l]), .b(d_mag[l]), .den(den_mag[l]), .side(lane_side[l]),
      .valid(mul_valid[l]), .prod(prod[l]), .den_o(mul_den[l]), .side_o(mul_side[l])
    );

    tpi_div #(.W(W), .SW(SW)) u_div (
      .clk(clk), .rst(rst), .en(en), .in_valid(mul_valid[l]),
      .prod(prod[l]), .den(mul_den[l]), .side(mul_side[l]),
      .valid(div_valid[l]), .quot(quot[l]), .side_o(div_side[l])
    );

    // Apply sign to the quotient and add to the edge start
    always_comb begin
      base_e = $signed({div_side[l][W-1], div_side[l][W-1:0]});
      sum_e  = div_side[l][W] ? base_e - $signed(quot[l]) : base_e + $signed(quot[l]);
      res[l] = div_side[l][W+1] ? FIELD_W'(sum_e) : '0;
    end
    assign lane_hit[l] = div_side[l][W+2];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid[0];
    end
    if (en) begin
      first_x  <= res[0];
      first_y  <= res[1];
      second_x <= res[2];
      second_y <= res[3];
      hit      <= &lane_hit;
    end
  end

  // Lanes run in lockstep
  `TPI_ASSERT_NOW(a_lanes_sync, div_valid[0], div_valid[1] && div_valid[2] && div_valid[3], "lane valid mismatch")
  // Without a hit there is no second point
  `TPI_ASSERT_NOW(a_no_hit_zero, out_valid && !hit, second_x == 0 && second_y == 0, "second point set without hit")
  // A held result blocks new requests
  `TPI_ASSERT_NOW(a_stall_blocks, out_valid && !out_ready, !in_ready, "request taken during stall")
  // A stalled result stays put
  `TPI_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(first_x) && $stable(hit), "result changed while stalled")

endmodule
